>>> hdl/hsp_pkg.sv
// Shared widths for the horizontal sphere push pipeline.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package hsp_pkg;

    localparam int unsigned COORD_W    = 32;  // coordinate field width
    localparam int unsigned RADIUS_W   = 30;  // radius field width
    localparam int unsigned MASS_W     = 16;  // mass field width
    localparam int unsigned MAG_W      = 31;  // magnitude of an overlapping axis offset
    localparam int unsigned SQ_W       = 2 * MAG_W;  // square of a magnitude
    localparam int unsigned MSUM_W     = MASS_W + 1;
    localparam int unsigned PROD_W     = MAG_W + MASS_W;
    localparam int unsigned S_TDATA_W  = 288;
    localparam int unsigned M_TDATA_W  = 136;

endpackage : hsp_pkg

`default_nettype wire

>>> hdl/horizontal_sphere_push_top.sv
// Top level of the horizontal sphere push pipeline: overlap test, push direction and mass split.
// Depends on hsp_pkg, hsp_isqrt_pipe and hsp_div_pipe.
//
//  Channel  | Direction | Contents
//  ---------+-----------+------------------------------------------------------------
//  s_       | in        | two sphere centres, radii, masses and push-enable flags
//  m_       | out       | overlap flag and horizontal push for each sphere
//
// Order: stages 1 to 4, square roots, stages 5 and 6, depth division, stage 7, mass division,
// stage 8; the three 31-stage units are the square root, depth division and mass division.
// A transaction may be accepted every cycle; the whole pipeline advances together.
// When the output register holds an untaken result, every stage holds and s_tready drops.
// Synchronous active-low reset clears the valid bits only.
`timescale 1ns / 1ps
`default_nettype none

module horizontal_sphere_push_top
    import hsp_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // [31:0] first_x, [63:32] first_y, [95:64] first_z, [127:96] second_x,
    // [159:128] second_y, [191:160] second_z, [221:192] first_radius,
    // [251:222] second_radius, [267:252] first_mass, [283:268] second_mass,
    // [284] apply_first, [285] apply_second, [287:286] zero
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // [0] hit, [32:1] first_push_x, [64:33] first_push_z,
    // [96:65] second_push_x, [128:97] second_push_z, [135:129] zero
    output logic      [M_TDATA_W-1:0] m_tdata
);

    localparam int unsigned DIFF_W = COORD_W + 1;

    // sidecar carried through the square-root unit
    typedef struct packed {
        logic              hit;
        logic              hzero;
        logic              sgn_x;
        logic              sgn_z;
        logic [MAG_W-1:0]  a_x;
        logic [MAG_W-1:0]  a_z;
        logic [MAG_W-1:0]  rsum;
        logic [MASS_W-1:0] m1;
        logic [MASS_W-1:0] m2;
    } root_tag_t;

    typedef struct packed {
        logic ap1;
        logic ap2;
    } flag_tag_t;

    // sidecar carried through the depth divider
    typedef struct packed {
        logic              hit;
        logic              hzero;
        logic              sgn_x;
        logic              sgn_z;
        logic [MASS_W-1:0] m1;
        logic [MASS_W-1:0] m2;
        logic              ap1;
        logic              ap2;
    } dir_tag_t;

    // sidecar carried through the mass divider
    typedef struct packed {
        logic hit;
        logic ok;
        logic sgn_x;
        logic sgn_z;
        logic ap1;
    } split_tag_t;

    logic en;

    // advance everything unless a finished result waits to be taken
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // ---------------------------------------------------------------- stage 1: offsets
    logic              v1_reg;
    logic [DIFF_W-1:0] d_x_reg, d_y_reg, d_z_reg;
    logic [MAG_W-1:0]  rsum1_reg;
    logic [MASS_W-1:0] m1_1_reg, m2_1_reg;
    logic              ap1_1_reg, ap2_1_reg;

    logic [DIFF_W-1:0] d_x_next, d_y_next, d_z_next;
    logic [MAG_W-1:0]  rsum1_next;

    assign d_x_next   = {s_tdata[31], s_tdata[31:0]}    - {s_tdata[127], s_tdata[127:96]};
    assign d_y_next   = {s_tdata[63], s_tdata[63:32]}   - {s_tdata[159], s_tdata[159:128]};
    assign d_z_next   = {s_tdata[95], s_tdata[95:64]}   - {s_tdata[191], s_tdata[191:160]};
    assign rsum1_next = {1'b0, s_tdata[221:192]} + {1'b0, s_tdata[251:222]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_x_reg   <= d_x_next;
            d_y_reg   <= d_y_next;
            d_z_reg   <= d_z_next;
            rsum1_reg <= rsum1_next;
            m1_1_reg  <= s_tdata[267:252];
            m2_1_reg  <= s_tdata[283:268];
            ap1_1_reg <= s_tdata[284];
            ap2_1_reg <= s_tdata[285];
        end
    end

    // ---------------------------------------------------------------- stage 2: magnitudes
    logic              v2_reg;
    logic [MAG_W-1:0]  a_x_reg, a_y_reg, a_z_reg;
    logic              far_reg, sgn_x2_reg, sgn_z2_reg;
    logic [MAG_W-1:0]  rsum2_reg;
    logic [MASS_W-1:0] m1_2_reg, m2_2_reg;
    logic              ap1_2_reg, ap2_2_reg;

    logic [DIFF_W-1:0] abs_x, abs_y, abs_z;

    assign abs_x = d_x_reg[DIFF_W-1] ? DIFF_W'(~d_x_reg + 1'b1) : d_x_reg;
    assign abs_y = d_y_reg[DIFF_W-1] ? DIFF_W'(~d_y_reg + 1'b1) : d_y_reg;
    assign abs_z = d_z_reg[DIFF_W-1] ? DIFF_W'(~d_z_reg + 1'b1) : d_z_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_x_reg    <= abs_x[MAG_W-1:0];
            a_y_reg    <= abs_y[MAG_W-1:0];
            a_z_reg    <= abs_z[MAG_W-1:0];
            // an axis offset of 2^31 or more can never overlap
            far_reg    <= |{abs_x[DIFF_W-1:MAG_W], abs_y[DIFF_W-1:MAG_W],
                            abs_z[DIFF_W-1:MAG_W]};
            sgn_x2_reg <= d_x_reg[DIFF_W-1];
            sgn_z2_reg <= d_z_reg[DIFF_W-1];
            rsum2_reg  <= rsum1_reg;
            m1_2_reg   <= m1_1_reg;
            m2_2_reg   <= m2_1_reg;
            ap1_2_reg  <= ap1_1_reg;
            ap2_2_reg  <= ap2_1_reg;
        end
    end

    // ---------------------------------------------------------------- stage 3: squares
    logic              v3_reg;
    logic [SQ_W-1:0]   sq_x_reg, sq_y_reg, sq_z_reg, rs2_reg;
    logic [MAG_W-1:0]  a_x3_reg, a_z3_reg, rsum3_reg;
    logic              far3_reg, sgn_x3_reg, sgn_z3_reg;
    logic [MASS_W-1:0] m1_3_reg, m2_3_reg;
    logic              ap1_3_reg, ap2_3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sq_x_reg   <= {{MAG_W{1'b0}}, a_x_reg} * {{MAG_W{1'b0}}, a_x_reg};
            sq_y_reg   <= {{MAG_W{1'b0}}, a_y_reg} * {{MAG_W{1'b0}}, a_y_reg};
            sq_z_reg   <= {{MAG_W{1'b0}}, a_z_reg} * {{MAG_W{1'b0}}, a_z_reg};
            rs2_reg    <= {{MAG_W{1'b0}}, rsum2_reg} * {{MAG_W{1'b0}}, rsum2_reg};
            a_x3_reg   <= a_x_reg;
            a_z3_reg   <= a_z_reg;
            rsum3_reg  <= rsum2_reg;
            far3_reg   <= far_reg;
            sgn_x3_reg <= sgn_x2_reg;
            sgn_z3_reg <= sgn_z2_reg;
            m1_3_reg   <= m1_2_reg;
            m2_3_reg   <= m2_2_reg;
            ap1_3_reg  <= ap1_2_reg;
            ap2_3_reg  <= ap2_2_reg;
        end
    end

    // ---------------------------------------------------------------- stage 4: overlap test
    logic              v4_reg;
    logic [SQ_W-1:0]   dist_reg, hl2_reg;
    root_tag_t         rtag_reg;
    flag_tag_t         ftag_reg;

    logic [SQ_W+1:0]   dist_sum;
    logic [SQ_W:0]     hl2_sum;
    logic              hit4;

    assign dist_sum = {2'b00, sq_x_reg} + {2'b00, sq_y_reg} + {2'b00, sq_z_reg};
    assign hl2_sum  = {1'b0, sq_x_reg} + {1'b0, sq_z_reg};
    assign hit4     = !far3_reg && (dist_sum < {2'b00, rs2_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (en) begin
            v4_reg <= v3_reg;
        end
    end

    // on a hit both sums stay below 2^62, so the low bits are the whole value
    always_ff @(posedge aclk) begin
        if (en) begin
            dist_reg       <= dist_sum[SQ_W-1:0];
            hl2_reg        <= hl2_sum[SQ_W-1:0];
            rtag_reg.hit   <= hit4;
            rtag_reg.hzero <= (hl2_sum == '0);
            rtag_reg.sgn_x <= sgn_x3_reg;
            rtag_reg.sgn_z <= sgn_z3_reg;
            rtag_reg.a_x   <= a_x3_reg;
            rtag_reg.a_z   <= a_z3_reg;
            rtag_reg.rsum  <= rsum3_reg;
            rtag_reg.m1    <= m1_3_reg;
            rtag_reg.m2    <= m2_3_reg;
            ftag_reg.ap1   <= ap1_3_reg;
            ftag_reg.ap2   <= ap2_3_reg;
        end
    end

    // ---------------------------------------------------------------- square roots
    logic             sd_vld, hl_vld;
    logic [MAG_W-1:0] sd_root, hl_root;
    root_tag_t        sd_tag;
    flag_tag_t        hl_tag;

    hsp_isqrt_pipe #(
        .N     (MAG_W),
        .TAG_W ($bits(root_tag_t))
    ) u_sqrt_dist (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_vld   (v4_reg),
        .in_rad   (dist_reg),
        .in_tag   (rtag_reg),
        .out_vld  (sd_vld),
        .out_root (sd_root),
        .out_tag  (sd_tag)
    );

    hsp_isqrt_pipe #(
        .N     (MAG_W),
        .TAG_W ($bits(flag_tag_t))
    ) u_sqrt_horiz (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_vld   (v4_reg),
        .in_rad   (hl2_reg),
        .in_tag   (ftag_reg),
        .out_vld  (hl_vld),
        .out_root (hl_root),
        .out_tag  (hl_tag)
    );

    // ---------------------------------------------------------------- stage 5: depth
    logic             v5_reg;
    logic [MAG_W-1:0] depth_reg, hl5_reg, a_x5_reg, a_z5_reg;
    dir_tag_t         dtag5_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5_reg <= 1'b0;
        end else if (en) begin
            v5_reg <= sd_vld & hl_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            depth_reg       <= sd_tag.rsum - sd_root;
            hl5_reg         <= hl_root;
            a_x5_reg        <= sd_tag.a_x;
            a_z5_reg        <= sd_tag.a_z;
            dtag5_reg.hit   <= sd_tag.hit;
            dtag5_reg.hzero <= sd_tag.hzero;
            dtag5_reg.sgn_x <= sd_tag.sgn_x;
            dtag5_reg.sgn_z <= sd_tag.sgn_z;
            dtag5_reg.m1    <= sd_tag.m1;
            dtag5_reg.m2    <= sd_tag.m2;
            dtag5_reg.ap1   <= hl_tag.ap1;
            dtag5_reg.ap2   <= hl_tag.ap2;
        end
    end

    // ---------------------------------------------------------------- stage 6: scale by depth
    logic             v6_reg;
    logic [SQ_W-1:0]  n_x_reg, n_z_reg;
    logic [MAG_W-1:0] hl6_reg;
    dir_tag_t         dtag6_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v6_reg <= 1'b0;
        end else if (en) begin
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            n_x_reg   <= {{MAG_W{1'b0}}, a_x5_reg} * {{MAG_W{1'b0}}, depth_reg};
            n_z_reg   <= {{MAG_W{1'b0}}, a_z5_reg} * {{MAG_W{1'b0}}, depth_reg};
            hl6_reg   <= hl5_reg;
            dtag6_reg <= dtag5_reg;
        end
    end

    // ---------------------------------------------------------------- divide by horizontal length
    logic             t_vld;
    logic [MAG_W-1:0] t_x, t_z;
    dir_tag_t         t_tag;

    hsp_div_pipe #(
        .NW    (SQ_W),
        .DW    (MAG_W),
        .QW    (MAG_W),
        .TAG_W ($bits(dir_tag_t))
    ) u_div_dir (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_vld    (v6_reg),
        .in_num_a  (n_x_reg),
        .in_num_b  (n_z_reg),
        .in_den    (hl6_reg),
        .in_tag    (dtag6_reg),
        .out_vld   (t_vld),
        .out_quo_a (t_x),
        .out_quo_b (t_z),
        .out_tag   (t_tag)
    );

    // ---------------------------------------------------------------- stage 7: mass weighting
    logic              v7_reg;
    logic [PROD_W-1:0] p_x1_reg, p_z1_reg, p_x2_reg, p_z2_reg;
    logic [MSUM_W-1:0] msum_reg;
    split_tag_t        stag_reg;
    logic              ap2_7_reg;

    logic [MSUM_W-1:0] msum_next;

    assign msum_next = {1'b0, t_tag.m1} + {1'b0, t_tag.m2};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v7_reg <= 1'b0;
        end else if (en) begin
            v7_reg <= t_vld;
        end
    end

    // the first sphere takes the share weighted by the other mass, and vice versa
    always_ff @(posedge aclk) begin
        if (en) begin
            p_x1_reg       <= {{MASS_W{1'b0}}, t_x} * {{MAG_W{1'b0}}, t_tag.m2};
            p_z1_reg       <= {{MASS_W{1'b0}}, t_z} * {{MAG_W{1'b0}}, t_tag.m2};
            p_x2_reg       <= {{MASS_W{1'b0}}, t_x} * {{MAG_W{1'b0}}, t_tag.m1};
            p_z2_reg       <= {{MASS_W{1'b0}}, t_z} * {{MAG_W{1'b0}}, t_tag.m1};
            msum_reg       <= msum_next;
            stag_reg.hit   <= t_tag.hit;
            stag_reg.ok    <= t_tag.hit && !t_tag.hzero && (msum_next != '0);
            stag_reg.sgn_x <= t_tag.sgn_x;
            stag_reg.sgn_z <= t_tag.sgn_z;
            stag_reg.ap1   <= t_tag.ap1;
            ap2_7_reg      <= t_tag.ap2;
        end
    end

    // ---------------------------------------------------------------- divide by mass sum
    logic             q1_vld, q2_vld;
    logic [MAG_W-1:0] q_x1, q_z1, q_x2, q_z2;
    split_tag_t       q_tag;
    logic             q_ap2;

    hsp_div_pipe #(
        .NW    (PROD_W),
        .DW    (MSUM_W),
        .QW    (MAG_W),
        .TAG_W ($bits(split_tag_t))
    ) u_div_first (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_vld    (v7_reg),
        .in_num_a  (p_x1_reg),
        .in_num_b  (p_z1_reg),
        .in_den    (msum_reg),
        .in_tag    (stag_reg),
        .out_vld   (q1_vld),
        .out_quo_a (q_x1),
        .out_quo_b (q_z1),
        .out_tag   (q_tag)
    );

    hsp_div_pipe #(
        .NW    (PROD_W),
        .DW    (MSUM_W),
        .QW    (MAG_W),
        .TAG_W (1)
    ) u_div_second (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_vld    (v7_reg),
        .in_num_a  (p_x2_reg),
        .in_num_b  (p_z2_reg),
        .in_den    (msum_reg),
        .in_tag    (ap2_7_reg),
        .out_vld   (q2_vld),
        .out_quo_a (q_x2),
        .out_quo_b (q_z2),
        .out_tag   (q_ap2)
    );

    // ---------------------------------------------------------------- stage 8: output register
    logic               out_vld_reg;
    logic [COORD_W-1:0] fpx_reg, fpz_reg, spx_reg, spz_reg;
    logic               hit_reg;

    logic [COORD_W-1:0] qx1_w, qz1_w, qx2_w, qz2_w;
    logic               en1, en2;

    assign qx1_w = {1'b0, q_x1};
    assign qz1_w = {1'b0, q_z1};
    assign qx2_w = {1'b0, q_x2};
    assign qz2_w = {1'b0, q_z2};
    assign en1   = q_tag.ok && q_tag.ap1;
    assign en2   = q_tag.ok && q_ap2;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (en) begin
            out_vld_reg <= q1_vld & q2_vld;
        end
    end

    // first sphere moves along the offset, second against it; drop refused pushes
    always_ff @(posedge aclk) begin
        if (en) begin
            hit_reg <= q_tag.hit;
            fpx_reg <= !en1 ? '0 : (q_tag.sgn_x ? COORD_W'(-qx1_w) : qx1_w);
            fpz_reg <= !en1 ? '0 : (q_tag.sgn_z ? COORD_W'(-qz1_w) : qz1_w);
            spx_reg <= !en2 ? '0 : (q_tag.sgn_x ? qx2_w : COORD_W'(-qx2_w));
            spz_reg <= !en2 ? '0 : (q_tag.sgn_z ? qz2_w : COORD_W'(-qz2_w));
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {7'b0, spz_reg, spx_reg, fpz_reg, fpx_reg, hit_reg};

`ifndef SYNTHESIS
    // no overlap means no push at all
    a_miss_no_push : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[0]) |-> (m_tdata[128:1] == '0))
        else $error("push reported without overlap");

    // the two spheres are pushed in opposite directions along x
    a_opposite_x : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[32:1] != '0) && (m_tdata[96:65] != '0))
            |-> (m_tdata[32] != m_tdata[96]))
        else $error("x pushes share a sign");

    // the two spheres are pushed in opposite directions along z
    a_opposite_z : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[64:33] != '0) && (m_tdata[128:97] != '0))
            |-> (m_tdata[64] != m_tdata[128]))
        else $error("z pushes share a sign");

    // a held result freezes the whole pipeline
    a_hold_blocks_input : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("input taken while output stalled");
`endif

endmodule : horizontal_sphere_push_top

`default_nettype wire

>>> hdl/hsp_isqrt_pipe.sv
// Pipelined integer square root, one root bit resolved per register stage.
// Depends on hsp_pkg for default widths.
`timescale 1ns / 1ps
`default_nettype none

module hsp_isqrt_pipe
    import hsp_pkg::*;
#(
    parameter int unsigned N     = MAG_W,  // root width; radicand is 2N bits
    parameter int unsigned TAG_W = 1
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             en,
    input  wire logic             in_vld,
    input  wire logic [2*N-1:0]   in_rad,
    input  wire logic [TAG_W-1:0] in_tag,
    output logic                  out_vld,
    output logic      [N-1:0]     out_root,
    output logic      [TAG_W-1:0] out_tag
);

    logic [N:0]       rem_reg  [N];
    logic [N-1:0]     root_reg [N];
    logic [2*N-1:0]   rad_reg  [N];
    logic [TAG_W-1:0] tag_reg  [N];
    logic             vld_reg  [N];

    for (genvar k = 0; k < N; k++) begin : g_stage
        logic [N:0]       src_rem;
        logic [N-1:0]     src_root;
        logic [2*N-1:0]   src_rad;
        logic [TAG_W-1:0] src_tag;
        logic             src_vld;
        logic [N+2:0]     cat;
        logic [N+2:0]     trial;
        logic             ge;

        if (k == 0) begin : g_first
            assign src_rem  = '0;
            assign src_root = '0;
            assign src_rad  = in_rad;
            assign src_tag  = in_tag;
            assign src_vld  = in_vld;
        end else begin : g_next
            assign src_rem  = rem_reg[k-1];
            assign src_root = root_reg[k-1];
            assign src_rad  = rad_reg[k-1];
            assign src_tag  = tag_reg[k-1];
            assign src_vld  = vld_reg[k-1];
        end

        // bring down the next radicand pair and try root*4+1
        assign cat   = {src_rem, src_rad[2*N-1 -: 2]};
        assign trial = {1'b0, src_root, 2'b01};
        assign ge    = (cat >= trial);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= src_vld;
            end
        end

        // the remainder can reach twice the root, so keep N+1 bits of it
        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k]  <= ge ? (N+1)'(cat - trial) : cat[N:0];
                root_reg[k] <= {src_root[N-2:0], ge};
                rad_reg[k]  <= {src_rad[2*N-3:0], 2'b00};
                tag_reg[k]  <= src_tag;
            end
        end
    end

    assign out_vld  = vld_reg[N-1];
    assign out_root = root_reg[N-1];
    assign out_tag  = tag_reg[N-1];

endmodule : hsp_isqrt_pipe

`default_nettype wire

>>> hdl/hsp_div_pipe.sv
// Two-lane pipelined restoring divider sharing one divisor, one quotient bit per stage.
// Depends on hsp_pkg for default widths.
`timescale 1ns / 1ps
`default_nettype none

module hsp_div_pipe
    import hsp_pkg::*;
#(
    parameter int unsigned NW    = SQ_W,   // dividend width
    parameter int unsigned DW    = MAG_W,  // divisor width, NW - QW <= DW
    parameter int unsigned QW    = MAG_W,  // quotient width, quotient < 2**QW
    parameter int unsigned TAG_W = 1
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             en,
    input  wire logic             in_vld,
    input  wire logic [NW-1:0]    in_num_a,
    input  wire logic [NW-1:0]    in_num_b,
    input  wire logic [DW-1:0]    in_den,
    input  wire logic [TAG_W-1:0] in_tag,
    output logic                  out_vld,
    output logic      [QW-1:0]    out_quo_a,
    output logic      [QW-1:0]    out_quo_b,
    output logic      [TAG_W-1:0] out_tag
);

    logic [DW-1:0]    rem_a_reg [QW];
    logic [DW-1:0]    rem_b_reg [QW];
    logic [QW-1:0]    lo_a_reg  [QW];   // dividend bits to go, quotient bits shifted in
    logic [QW-1:0]    lo_b_reg  [QW];
    logic [DW-1:0]    den_reg   [QW];
    logic [TAG_W-1:0] tag_reg   [QW];
    logic             vld_reg   [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [DW-1:0]    src_rem_a, src_rem_b, src_den;
        logic [QW-1:0]    src_lo_a, src_lo_b;
        logic [TAG_W-1:0] src_tag;
        logic             src_vld;
        logic [DW:0]      cat_a, cat_b;
        logic             ge_a, ge_b;

        if (k == 0) begin : g_first
            assign src_rem_a = DW'(in_num_a >> QW);
            assign src_rem_b = DW'(in_num_b >> QW);
            assign src_lo_a  = in_num_a[QW-1:0];
            assign src_lo_b  = in_num_b[QW-1:0];
            assign src_den   = in_den;
            assign src_tag   = in_tag;
            assign src_vld   = in_vld;
        end else begin : g_next
            assign src_rem_a = rem_a_reg[k-1];
            assign src_rem_b = rem_b_reg[k-1];
            assign src_lo_a  = lo_a_reg[k-1];
            assign src_lo_b  = lo_b_reg[k-1];
            assign src_den   = den_reg[k-1];
            assign src_tag   = tag_reg[k-1];
            assign src_vld   = vld_reg[k-1];
        end

        assign cat_a = {src_rem_a, src_lo_a[QW-1]};
        assign cat_b = {src_rem_b, src_lo_b[QW-1]};
        assign ge_a  = (cat_a >= {1'b0, src_den});
        assign ge_b  = (cat_b >= {1'b0, src_den});

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= src_vld;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_a_reg[k] <= ge_a ? DW'(cat_a - {1'b0, src_den}) : cat_a[DW-1:0];
                rem_b_reg[k] <= ge_b ? DW'(cat_b - {1'b0, src_den}) : cat_b[DW-1:0];
                lo_a_reg[k]  <= {src_lo_a[QW-2:0], ge_a};
                lo_b_reg[k]  <= {src_lo_b[QW-2:0], ge_b};
                den_reg[k]   <= src_den;
                tag_reg[k]   <= src_tag;
            end
        end
    end

    assign out_vld   = vld_reg[QW-1];
    assign out_quo_a = lo_a_reg[QW-1];
    assign out_quo_b = lo_b_reg[QW-1];
    assign out_tag   = tag_reg[QW-1];

endmodule : hsp_div_pipe

`default_nettype wire
